>>> rtl/lru_block_tag_cache_unit_defines.svh
// Assertion macros used by the block tag cache datapath.
`ifndef LRU_BLOCK_TAG_CACHE_UNIT_DEFINES_SVH
`define LRU_BLOCK_TAG_CACHE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LBTC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbtc check failed");

// Next-cycle implication, checked out of reset.
`define LBTC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbtc check failed");

`endif

>>> rtl/lbtc_pkg.sv
// Types, constants and helpers for the block tag cache.
`default_nettype none

package lbtc_pkg;

    localparam int WAYS_DEFAULT = 64;
    localparam int BLK_W        = 64;
    localparam int STAMP_W      = 64;
    localparam int CNT_W        = 32;
    localparam int WAY_OUT_W    = 6;
    localparam int CFG_W        = 7;

    localparam logic [1:0] REQ_LOOKUP     = 2'd0;
    localparam logic [1:0] REQ_FILL       = 2'd1;
    localparam logic [1:0] REQ_INVALIDATE = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [BLK_W-1:0] block_num;
    } req_t;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic                 evicted;
        logic [BLK_W-1:0]     evicted_block;
        logic [CNT_W-1:0]     hit_count;
        logic [CNT_W-1:0]     miss_count;
        logic [CNT_W-1:0]     eviction_count;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_end;
        logic out_free;
    } ctl_stat_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

`default_nettype wire

>>> rtl/lbtc_ctrl.sv
// Request sequencer: accept, way scan, commit.
`default_nettype none

module lbtc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire lbtc_pkg::ctl_stat_t stat,
    output lbtc_pkg::ctl_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready  = (state_reg == ST_IDLE);
    assign cmd.load   = req_valid && req_ready;
    assign cmd.issue  = (state_reg == ST_SCAN) && !stat.scan_end;
    assign cmd.commit = (state_reg == ST_UPDATE) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_end)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/lbtc_dp.sv
// Way table, scan trackers, LRU victim choice, counters and result register.
`default_nettype none
`include "lru_block_tag_cache_unit_defines.svh"

module lbtc_dp #(
    parameter int WAYS = lbtc_pkg::WAYS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lbtc_pkg::ctl_cmd_t            cmd,
    output lbtc_pkg::ctl_stat_t                stat,
    input  wire lbtc_pkg::req_t                req,
    input  wire logic                          cfg_we,
    input  wire logic [lbtc_pkg::CFG_W-1:0]    cfg_data,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output lbtc_pkg::rsp_t                     rsp
);

    localparam int AW     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CW_RAW = $clog2(WAYS + 1);
    localparam int NW     = (CW_RAW > lbtc_pkg::CFG_W) ? CW_RAW : lbtc_pkg::CFG_W;

    typedef struct packed {
        logic [lbtc_pkg::BLK_W-1:0]   tag;
        logic [lbtc_pkg::STAMP_W-1:0] stamp;
    } entry_t;

    entry_t entry_mem [WAYS];

    logic [WAYS-1:0]               valid_reg;
    logic [NW-1:0]                 n_reg;
    logic [NW-1:0]                 n_next;
    logic [NW-1:0]                 scan_idx_reg;
    logic [1:0]                    req_type_reg;
    logic [lbtc_pkg::BLK_W-1:0]    blk_reg;
    logic [lbtc_pkg::STAMP_W-1:0]  clock_reg;
    logic [lbtc_pkg::CNT_W-1:0]    hits_reg;
    logic [lbtc_pkg::CNT_W-1:0]    misses_reg;
    logic [lbtc_pkg::CNT_W-1:0]    evicts_reg;

    entry_t                        rd_entry_reg;
    logic                          rd_valid_reg;
    logic                          eval_reg;
    logic [AW-1:0]                 eval_idx_reg;

    logic                          found_reg;
    logic [AW-1:0]                 found_way_reg;
    logic                          empty_found_reg;
    logic [AW-1:0]                 empty_way_reg;
    logic                          best_set_reg;
    logic [AW-1:0]                 best_way_reg;
    logic [lbtc_pkg::STAMP_W-1:0]  best_stamp_reg;
    logic [lbtc_pkg::BLK_W-1:0]    best_tag_reg;

    logic                          rsp_valid_reg;
    lbtc_pkg::rsp_t                rsp_reg;

    logic [AW-1:0]                 rd_addr;
    logic                          match;
    logic                          hit_c;
    logic [AW-1:0]                 way_c;
    logic                          ev_c;
    logic [lbtc_pkg::BLK_W-1:0]    ev_blk_c;
    logic [lbtc_pkg::CNT_W-1:0]    hits_c;
    logic [lbtc_pkg::CNT_W-1:0]    misses_c;
    logic [lbtc_pkg::CNT_W-1:0]    evicts_c;
    logic                          wr_en_c;
    logic [AW-1:0]                 wr_addr_c;
    logic                          set_valid_c;
    logic                          clr_valid_c;
    logic [lbtc_pkg::STAMP_W-1:0]  stamp_c;

    assign rd_addr       = scan_idx_reg[AW-1:0];
    assign stat.scan_end = (scan_idx_reg >= n_reg);
    assign stat.out_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid     = rsp_valid_reg;
    assign rsp           = rsp_reg;

    // clamp the requested way count to the table depth
    assign n_next = (NW'(cfg_data) > NW'(WAYS)) ? NW'(WAYS) : NW'(cfg_data);

    assign match   = rd_valid_reg && (blk_reg != '0) && (rd_entry_reg.tag == blk_reg);
    assign stamp_c = clock_reg + 1'b1;

    always_comb
    begin
        hit_c       = 1'b0;
        way_c       = '0;
        ev_c        = 1'b0;
        ev_blk_c    = '0;
        hits_c      = hits_reg;
        misses_c    = misses_reg;
        evicts_c    = evicts_reg;
        wr_en_c     = 1'b0;
        wr_addr_c   = found_way_reg;
        set_valid_c = 1'b0;
        clr_valid_c = 1'b0;
        unique case (req_type_reg)
            lbtc_pkg::REQ_LOOKUP:
            begin
                if (found_reg)
                begin
                    hit_c   = 1'b1;
                    way_c   = found_way_reg;
                    wr_en_c = 1'b1;
                    hits_c  = lbtc_pkg::sat_inc(hits_reg);
                end
            end
            lbtc_pkg::REQ_FILL:
            begin
                misses_c = lbtc_pkg::sat_inc(misses_reg);
                if (found_reg)
                begin
                    hit_c   = 1'b1;
                    way_c   = found_way_reg;
                    wr_en_c = 1'b1;
                end
                else if ((blk_reg != '0) && (n_reg != '0))
                begin
                    wr_en_c     = 1'b1;
                    set_valid_c = 1'b1;
                    if (empty_found_reg)
                    begin
                        wr_addr_c = empty_way_reg;
                    end
                    else
                    begin
                        wr_addr_c = best_way_reg;
                        ev_c      = 1'b1;
                        ev_blk_c  = best_tag_reg;
                        evicts_c  = lbtc_pkg::sat_inc(evicts_reg);
                    end
                    way_c = wr_addr_c;
                end
            end
            lbtc_pkg::REQ_INVALIDATE:
            begin
                if (found_reg)
                begin
                    hit_c       = 1'b1;
                    way_c       = found_way_reg;
                    clr_valid_c = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // table storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en_c)
        begin
            entry_mem[wr_addr_c] <= '{tag: blk_reg, stamp: stamp_c};
        end
        if (cmd.issue)
        begin
            rd_entry_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= req.req_type;
            blk_reg      <= req.block_num;
        end
        if (cmd.issue)
        begin
            eval_idx_reg <= rd_addr;
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (eval_reg && match && !found_reg)
        begin
            found_way_reg <= eval_idx_reg;
        end
        if (eval_reg && !rd_valid_reg && !empty_found_reg)
        begin
            empty_way_reg <= eval_idx_reg;
        end
        if (eval_reg && rd_valid_reg &&
            (!best_set_reg || (rd_entry_reg.stamp < best_stamp_reg)))
        begin
            best_way_reg   <= eval_idx_reg;
            best_stamp_reg <= rd_entry_reg.stamp;
            best_tag_reg   <= rd_entry_reg.tag;
        end
        if (cmd.commit)
        begin
            rsp_reg.hit            <= hit_c;
            rsp_reg.way            <= lbtc_pkg::WAY_OUT_W'(way_c);
            rsp_reg.evicted        <= ev_c;
            rsp_reg.evicted_block  <= ev_blk_c;
            rsp_reg.hit_count      <= hits_c;
            rsp_reg.miss_count     <= misses_c;
            rsp_reg.eviction_count <= evicts_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            n_reg           <= NW'(WAYS);
            scan_idx_reg    <= '0;
            clock_reg       <= '0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            evicts_reg      <= '0;
            eval_reg        <= 1'b0;
            found_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
            best_set_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            eval_reg <= cmd.issue;
            if (cmd.load)
            begin
                scan_idx_reg    <= '0;
                found_reg       <= 1'b0;
                empty_found_reg <= 1'b0;
                best_set_reg    <= 1'b0;
            end
            else if (cmd.issue)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (eval_reg && match)
            begin
                found_reg <= 1'b1;
            end
            if (eval_reg && !rd_valid_reg)
            begin
                empty_found_reg <= 1'b1;
            end
            if (eval_reg && rd_valid_reg)
            begin
                best_set_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                n_reg      <= n_next;
                valid_reg  <= '0;
                hits_reg   <= '0;
                misses_reg <= '0;
                evicts_reg <= '0;
            end
            else if (cmd.commit)
            begin
                hits_reg   <= hits_c;
                misses_reg <= misses_c;
                evicts_reg <= evicts_c;
                if (wr_en_c)
                begin
                    clock_reg <= stamp_c;
                end
                if (set_valid_c)
                begin
                    valid_reg[wr_addr_c] <= 1'b1;
                end
                if (clr_valid_c)
                begin
                    valid_reg[found_way_reg] <= 1'b0;
                end
            end
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    `LBTC_ASSERT_IMP(a_evict_not_hit, rsp_valid_reg && rsp_reg.evicted, !rsp_reg.hit && (rsp_reg.evicted_block != '0))
    `LBTC_ASSERT_NXT(a_commit_shows, cmd.commit, rsp_valid_reg)
    `LBTC_ASSERT_IMP(a_found_nonzero, found_reg, blk_reg != '0)
    `LBTC_ASSERT_IMP(a_eval_after_issue, eval_reg, $past(cmd.issue))

endmodule

`default_nettype wire

>>> rtl/lru_block_tag_cache_unit.sv
// Block tag cache: fully associative block directory with timestamp LRU.
//
// Request channel req_valid/req_ready carries req (req_type, block_num); one
// response beat on rsp_valid/rsp_ready follows every request beat, in order.
// A request beat is taken only while the unit is idle. The way table is read
// one way per cycle through the single table read port, and each request
// passes through accept, a scan of the active ways and a commit before the
// unit is ready for the next request beat.
// The response is registered and appears on the cycle after commit.
// If the receiver stalls, the finished beat waits in the response register;
// the next request is taken and scanned meanwhile, and its commit waits until
// the register frees.
// cfg_we writes the active way count from cfg_data; it empties the table and
// clears the counters. Write it only with no request in flight.
// Reset empties every way at once (valid bits), restores the full way count
// and clears the counters and the recency clock; no clearing sweep is needed.
`default_nettype none

module lru_block_tag_cache_unit #(
    parameter int WAYS = lbtc_pkg::WAYS_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire lbtc_pkg::req_t             req,
    output logic                            rsp_valid,
    input  wire logic                       rsp_ready,
    output lbtc_pkg::rsp_t                  rsp,
    input  wire logic                       cfg_we,
    input  wire logic [lbtc_pkg::CFG_W-1:0] cfg_data
);

    lbtc_pkg::ctl_cmd_t  cmd;
    lbtc_pkg::ctl_stat_t stat;

    lbtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lbtc_dp #(
        .WAYS (WAYS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
